// File: hw/rtl/trlseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlseq_pkg: shared types and codes of the two-road traffic light sequencer
// Phase codes, configuration bundle and result word layout.
// ----------------------------------------------------------------------------
package trlseq_pkg;

  localparam int unsigned LenW   = 7;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DigitW = 4;

  // register indexes on the configuration port
  localparam logic [2:0] RegSouthPhaseLen   = 3'd0;
  localparam logic [2:0] RegSouthYellowLen  = 3'd1;
  localparam logic [2:0] RegWestYellowLen   = 3'd2;
  localparam logic [2:0] RegWestGreenLen    = 3'd3;
  localparam logic [2:0] RegManualChangeLen = 3'd4;

  // reset values of the length registers
  localparam logic [LenW-1:0] SouthPhaseLenRst   = 7'd15;
  localparam logic [LenW-1:0] SouthYellowLenRst  = 7'd3;
  localparam logic [LenW-1:0] WestYellowLenRst   = 7'd3;
  localparam logic [LenW-1:0] WestGreenLenRst    = 7'd20;
  localparam logic [LenW-1:0] ManualChangeLenRst = 7'd3;

  // phase codes
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhSouth = 3'd1;
  localparam logic [PhaseW-1:0] PhWestY = 3'd2;
  localparam logic [PhaseW-1:0] PhWestG = 3'd3;
  localparam logic [PhaseW-1:0] PhChgW  = 3'd4;
  localparam logic [PhaseW-1:0] PhChgS  = 3'd5;
  localparam logic [PhaseW-1:0] PhHoldW = 3'd6;
  localparam logic [PhaseW-1:0] PhHoldS = 3'd7;

  // largest count the two digits can show
  localparam logic [LenW-1:0] ShownMax = 7'd99;

  typedef struct packed {
    logic [LenW-1:0] manual_change_len;
    logic [LenW-1:0] west_green_len;
    logic [LenW-1:0] west_yellow_len;
    logic [LenW-1:0] south_yellow_len;
    logic [LenW-1:0] south_phase_len;
  } cfg_t;

  // declared msb first so the last field lands in bit 0 when packed
  typedef struct packed {
    logic              display_high_on;
    logic              display_low_on;
    logic [DigitW-1:0] count_units;
    logic [DigitW-1:0] count_tens;
    logic              south_green;
    logic              south_yellow;
    logic              south_red;
    logic              west_green;
    logic              west_yellow;
    logic              west_red;
  } result_t;

endpackage

// File: hw/rtl/trlseq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlseq_step: one-tick update of the sequencer
// Next phase and countdown from the current state and switches, plus the
// lamp and digit word for the second that the tick starts.
// ----------------------------------------------------------------------------
module trlseq_step (
  input  logic [trlseq_pkg::PhaseW-1:0] phase_i,
  input  logic [trlseq_pkg::LenW-1:0]   remaining_i,
  input  trlseq_pkg::cfg_t              cfg_i,
  input  logic                          manual_enable_i,
  input  logic                          manual_south_i,
  output logic [trlseq_pkg::PhaseW-1:0] phase_o,
  output logic [trlseq_pkg::LenW-1:0]   remaining_o,
  output trlseq_pkg::result_t           result_o
);

  logic                          counting;
  logic                          in_south;
  logic [trlseq_pkg::LenW:0]     yellow_sum;
  logic                          lit;
  logic [trlseq_pkg::LenW-1:0]   shown;
  logic [14:0]                   tens_prod;
  logic [trlseq_pkg::DigitW-1:0] tens;
  logic [trlseq_pkg::LenW-1:0]   tens_x10;
  logic [trlseq_pkg::LenW-1:0]   units;

  // a zero length still gives a one-second phase
  function automatic logic [trlseq_pkg::LenW-1:0] fix_len(
    input logic [trlseq_pkg::LenW-1:0] len
  );
    fix_len = (len == '0) ? trlseq_pkg::LenW'(1) : len;
  endfunction

  always_comb begin
    phase_o     = phase_i;
    remaining_o = remaining_i;
    counting    = (phase_i != trlseq_pkg::PhIdle) &&
                  (phase_i != trlseq_pkg::PhHoldW) &&
                  (phase_i != trlseq_pkg::PhHoldS);

    if (counting && (remaining_i > trlseq_pkg::LenW'(1))) begin
      remaining_o = remaining_i - trlseq_pkg::LenW'(1);
    end else if (counting && (phase_i == trlseq_pkg::PhSouth)) begin
      phase_o     = trlseq_pkg::PhWestY;
      remaining_o = fix_len(cfg_i.west_yellow_len);
    end else if (counting && (phase_i == trlseq_pkg::PhWestY)) begin
      phase_o     = trlseq_pkg::PhWestG;
      remaining_o = fix_len(cfg_i.west_green_len);
    end else if (!manual_enable_i) begin
      phase_o     = trlseq_pkg::PhSouth;
      remaining_o = fix_len(cfg_i.south_phase_len);
    end else if (manual_south_i) begin
      if ((phase_i == trlseq_pkg::PhChgS) || (phase_i == trlseq_pkg::PhHoldS)) begin
        phase_o     = trlseq_pkg::PhHoldS;
        remaining_o = '0;
      end else begin
        phase_o     = trlseq_pkg::PhChgS;
        remaining_o = fix_len(cfg_i.manual_change_len);
      end
    end else begin
      if ((phase_i == trlseq_pkg::PhChgW) || (phase_i == trlseq_pkg::PhHoldW)) begin
        phase_o     = trlseq_pkg::PhHoldW;
        remaining_o = '0;
      end else begin
        phase_o     = trlseq_pkg::PhChgW;
        remaining_o = fix_len(cfg_i.manual_change_len);
      end
    end
  end

  // lamps for the new phase
  always_comb begin
    result_o   = '0;
    in_south   = 1'b0;
    yellow_sum = {1'b0, remaining_o} + {1'b0, cfg_i.south_yellow_len};
    case (phase_o)
      trlseq_pkg::PhSouth: begin
        in_south                = 1'b1;
        result_o.west_red       = 1'b1;
        result_o.south_yellow   = yellow_sum > {1'b0, cfg_i.south_phase_len};
        result_o.south_green    = !(yellow_sum > {1'b0, cfg_i.south_phase_len});
        result_o.display_low_on = 1'b1;
        result_o.display_high_on = 1'b1;
      end
      trlseq_pkg::PhWestY: begin
        result_o.south_red       = 1'b1;
        result_o.west_yellow     = 1'b1;
        result_o.display_low_on  = 1'b1;
        result_o.display_high_on = 1'b1;
      end
      trlseq_pkg::PhWestG: begin
        result_o.south_red       = 1'b1;
        result_o.west_green      = 1'b1;
        result_o.display_low_on  = 1'b1;
        result_o.display_high_on = 1'b1;
      end
      trlseq_pkg::PhChgW: begin
        result_o.south_red      = 1'b1;
        result_o.west_yellow    = 1'b1;
        result_o.display_low_on = 1'b1;
      end
      trlseq_pkg::PhChgS: begin
        result_o.west_red        = 1'b1;
        result_o.south_yellow    = 1'b1;
        result_o.display_high_on = 1'b1;
      end
      trlseq_pkg::PhHoldW: begin
        result_o.south_red  = 1'b1;
        result_o.west_green = 1'b1;
      end
      default: begin
        result_o.west_red    = 1'b1;
        result_o.south_green = 1'b1;
      end
    endcase

    // digits: saturate, then split by reciprocal multiply (exact below 100)
    lit       = result_o.display_low_on || result_o.display_high_on || in_south;
    shown     = !lit ? '0 :
                (remaining_o > trlseq_pkg::ShownMax) ? trlseq_pkg::ShownMax : remaining_o;
    tens_prod = {8'd0, shown} * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units     = shown - tens_x10;
    result_o.count_tens  = tens;
    result_o.count_units = units[trlseq_pkg::DigitW-1:0];
  end

endmodule

// File: hw/rtl/two_road_traffic_light_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_road_traffic_light_sequencer_top: tick-driven two-road light sequencer
// Output: the result word of an accepted tick word is registered in the output
//   register, or in the skid entry while the master side stalls.
// Throughput: one tick word per cycle while the skid entry is empty; the state update is a single pass.
// A two-entry output stage (main plus skid) absorbs master-side stalls.
// Reset clears phase, countdown, output valids and restores the length
//   registers to their defaults.
// ----------------------------------------------------------------------------
module two_road_traffic_light_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // tick words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] manual_enable, [1] manual_south, [7:2] zero
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] west_red, [1] west_yellow, [2] west_green,
                                     // [3] south_red, [4] south_yellow, [5] south_green,
                                     // [9:6] count_tens, [13:10] count_units,
                                     // [14] display_low_on, [15] display_high_on
);

  trlseq_pkg::cfg_t                cfg_q;
  logic [trlseq_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [trlseq_pkg::LenW-1:0]     remaining_q, remaining_d;
  trlseq_pkg::result_t             step_res;
  trlseq_pkg::result_t             out_q, skid_q;
  logic                            out_vld_q, skid_vld_q;
  logic                            in_acc, out_acc;

  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.south_phase_len   <= trlseq_pkg::SouthPhaseLenRst;
      cfg_q.south_yellow_len  <= trlseq_pkg::SouthYellowLenRst;
      cfg_q.west_yellow_len   <= trlseq_pkg::WestYellowLenRst;
      cfg_q.west_green_len    <= trlseq_pkg::WestGreenLenRst;
      cfg_q.manual_change_len <= trlseq_pkg::ManualChangeLenRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trlseq_pkg::RegSouthPhaseLen:   cfg_q.south_phase_len   <= cfg_data_i;
        trlseq_pkg::RegSouthYellowLen:  cfg_q.south_yellow_len  <= cfg_data_i;
        trlseq_pkg::RegWestYellowLen:   cfg_q.west_yellow_len   <= cfg_data_i;
        trlseq_pkg::RegWestGreenLen:    cfg_q.west_green_len    <= cfg_data_i;
        trlseq_pkg::RegManualChangeLen: cfg_q.manual_change_len <= cfg_data_i;
        default: ;
      endcase
    end
  end

  trlseq_step u_step (
    .phase_i         (phase_q),
    .remaining_i     (remaining_q),
    .cfg_i           (cfg_q),
    .manual_enable_i (s_axis_tdata[0]),
    .manual_south_i  (s_axis_tdata[1]),
    .phase_o         (phase_d),
    .remaining_o     (remaining_d),
    .result_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= trlseq_pkg::PhIdle;
      remaining_q <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_acc) begin
        out_vld_q  <= skid_vld_q || in_acc;
        skid_vld_q <= 1'b0;
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      out_q <= skid_vld_q ? skid_q : step_res;
    end
    if (in_acc && out_vld_q && !out_acc) begin
      skid_q <= step_res;
    end
  end

  // hold phases never carry a countdown
  a_hold_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == trlseq_pkg::PhHoldW) || (phase_q == trlseq_pkg::PhHoldS))
      |-> (remaining_q == '0))
    else $error("hold phase with nonzero countdown");

  // counting phases always have at least one second left
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q != trlseq_pkg::PhIdle) && (phase_q != trlseq_pkg::PhHoldW) &&
     (phase_q != trlseq_pkg::PhHoldS)) |-> (remaining_q != '0))
    else $error("counting phase with empty countdown");

  // the skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  // dark displays show zero digits
  a_dark_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.display_low_on && !out_q.display_high_on)
      |-> ((out_q.count_tens == '0) && (out_q.count_units == '0)))
    else $error("digits nonzero with displays dark");

  // exactly one lamp per road
  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($onehot({out_q.west_red, out_q.west_yellow, out_q.west_green}) &&
                   $onehot({out_q.south_red, out_q.south_yellow, out_q.south_green})))
    else $error("road without exactly one lamp lit");

endmodule

// File: bench/two_road_traffic_light_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_road_traffic_light_sequencer_top_tb: self-checking bench for the sequencer
// Feeds tick words through a queue-driven driver and checks every result word
// against an in-bench model of the phase and countdown logic. Register sets
// change between runs, covering reset values, zero lengths, 127-second
// lengths and a yellow length at or above the south phase.
// ----------------------------------------------------------------------------
module two_road_traffic_light_sequencer_top_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TicksPerRun = 210;
  localparam int unsigned NumRuns     = 9;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = trlseq_pkg::RegSouthPhaseLen;
  logic [6:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // model state and register copy
  trlseq_pkg::cfg_t                  lens;
  logic [trlseq_pkg::PhaseW-1:0]     seq_phase;
  logic [trlseq_pkg::LenW-1:0]       seq_left;

  logic [7:0]           tick_q[$];
  trlseq_pkg::result_t  lights_due_q[$];
  trlseq_pkg::result_t  mon_got;
  trlseq_pkg::result_t  mon_want;
  bit          no_idle      = 1'b0;
  int unsigned err_cnt      = 0;
  int unsigned ticks_taken  = 0;
  int unsigned words_checked = 0;
  int unsigned hold_words   = 0;
  int unsigned capped_words = 0;
  int unsigned cycle_cnt    = 0;

  two_road_traffic_light_sequencer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // [0] manual_enable, [1] manual_south, [7:2] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)   // [0] west_red .. [5] south_green, [9:6] count_tens,
                                    // [13:10] count_units, [14] display_low_on,
                                    // [15] display_high_on
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void enter_phase(logic [trlseq_pkg::PhaseW-1:0] ph,
                                      logic [trlseq_pkg::LenW-1:0] len);
    seq_phase = ph;
    seq_left  = (len == '0) ? 7'd1 : len;
  endfunction

  // switch sampling at a cycle end, a change end, or an idle or hold tick
  function automatic void choose_phase(logic en, logic so);
    if (!en) begin
      enter_phase(trlseq_pkg::PhSouth, lens.south_phase_len);
    end else if (so) begin
      if (seq_phase == trlseq_pkg::PhChgS || seq_phase == trlseq_pkg::PhHoldS) begin
        seq_phase = trlseq_pkg::PhHoldS;
        seq_left  = '0;
      end else begin
        enter_phase(trlseq_pkg::PhChgS, lens.manual_change_len);
      end
    end else begin
      if (seq_phase == trlseq_pkg::PhChgW || seq_phase == trlseq_pkg::PhHoldW) begin
        seq_phase = trlseq_pkg::PhHoldW;
        seq_left  = '0;
      end else begin
        enter_phase(trlseq_pkg::PhChgW, lens.manual_change_len);
      end
    end
  endfunction

  function automatic trlseq_pkg::result_t predict_lights(logic en, logic so);
    trlseq_pkg::result_t         r;
    logic [trlseq_pkg::LenW-1:0] shown;
    r = '0;
    case (seq_phase)
      trlseq_pkg::PhSouth, trlseq_pkg::PhWestY, trlseq_pkg::PhWestG,
      trlseq_pkg::PhChgW, trlseq_pkg::PhChgS: begin
        if (seq_left > 7'd1) seq_left = seq_left - 7'd1;
        else if (seq_phase == trlseq_pkg::PhSouth)
          enter_phase(trlseq_pkg::PhWestY, lens.west_yellow_len);
        else if (seq_phase == trlseq_pkg::PhWestY)
          enter_phase(trlseq_pkg::PhWestG, lens.west_green_len);
        else choose_phase(en, so);
      end
      default: choose_phase(en, so);
    endcase
    case (seq_phase)
      trlseq_pkg::PhSouth: begin
        r.west_red = 1'b1;
        // yellow test always against the current registers
        if (int'(seq_left) + int'(lens.south_yellow_len) > int'(lens.south_phase_len)) begin
          r.south_yellow = 1'b1;
        end else begin
          r.south_green = 1'b1;
        end
        r.display_low_on  = 1'b1;
        r.display_high_on = 1'b1;
      end
      trlseq_pkg::PhWestY: begin
        r.south_red       = 1'b1;
        r.west_yellow     = 1'b1;
        r.display_low_on  = 1'b1;
        r.display_high_on = 1'b1;
      end
      trlseq_pkg::PhWestG: begin
        r.south_red       = 1'b1;
        r.west_green      = 1'b1;
        r.display_low_on  = 1'b1;
        r.display_high_on = 1'b1;
      end
      trlseq_pkg::PhChgW: begin
        r.south_red      = 1'b1;
        r.west_yellow    = 1'b1;
        r.display_low_on = 1'b1;
      end
      trlseq_pkg::PhChgS: begin
        r.west_red        = 1'b1;
        r.south_yellow    = 1'b1;
        r.display_high_on = 1'b1;
      end
      trlseq_pkg::PhHoldW: begin
        r.south_red  = 1'b1;
        r.west_green = 1'b1;
      end
      default: begin
        r.west_red    = 1'b1;
        r.south_green = 1'b1;
      end
    endcase
    if (r.display_low_on || r.display_high_on) begin
      shown = (seq_left > trlseq_pkg::ShownMax) ? trlseq_pkg::ShownMax : seq_left;
      r.count_tens  = trlseq_pkg::DigitW'(shown / 7'd10);
      r.count_units = trlseq_pkg::DigitW'(shown % 7'd10);
    end
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  function automatic void add_tick(logic en, logic so);
    tick_q.push_back({6'b0, so, en});
  endfunction

  // mostly auto runs, interleaved with manual runs with noise and single random ticks
  task automatic fill_random(int unsigned count);
    int unsigned n;
    int unsigned run;
    int unsigned pick;
    logic        so;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        run = $urandom_range(1, 40);
        repeat (run) add_tick(1'b0, 1'($urandom));
      end else if (pick < 90) begin
        so  = 1'($urandom);
        run = $urandom_range(1, 15);
        repeat (run) add_tick(1'b1, ($urandom_range(0, 9) == 0) ? !so : so);
      end else begin
        run = 1;
        add_tick(1'($urandom), 1'($urandom));
      end
      n += run;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [trlseq_pkg::LenW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      trlseq_pkg::RegSouthPhaseLen:   lens.south_phase_len   = val;
      trlseq_pkg::RegSouthYellowLen:  lens.south_yellow_len  = val;
      trlseq_pkg::RegWestYellowLen:   lens.west_yellow_len   = val;
      trlseq_pkg::RegWestGreenLen:    lens.west_green_len    = val;
      trlseq_pkg::RegManualChangeLen: lens.manual_change_len = val;
      default: ;
    endcase
  endtask

  task automatic set_lengths(logic [trlseq_pkg::LenW-1:0] spl,
                             logic [trlseq_pkg::LenW-1:0] syl,
                             logic [trlseq_pkg::LenW-1:0] wyl,
                             logic [trlseq_pkg::LenW-1:0] wgl,
                             logic [trlseq_pkg::LenW-1:0] mcl, bit hit_unused);
    write_reg(trlseq_pkg::RegSouthPhaseLen, spl);
    write_reg(trlseq_pkg::RegSouthYellowLen, syl);
    write_reg(trlseq_pkg::RegWestYellowLen, wyl);
    write_reg(trlseq_pkg::RegWestGreenLen, wgl);
    write_reg(trlseq_pkg::RegManualChangeLen, mcl);
    if (hit_unused) begin
      for (int idx = int'(trlseq_pkg::RegManualChangeLen) + 1; idx < 8; idx++) begin
        write_reg(3'(idx), 7'($urandom));
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every tick word is taken and every result word has come back
  task automatic drain_lights();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || lights_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(negedge clk_i);
  endtask

  // driver: the prediction is made when a tick word is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lights_due_q.push_back(predict_lights(s_axis_tdata[0], s_axis_tdata[1]));
        ticks_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10)) begin
          s_axis_tdata  <= tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got = m_axis_tdata;
        if (lights_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result word %h arrived with nothing expected", $time, m_axis_tdata);
        end else begin
          mon_want = lights_due_q.pop_front();
          compare_field("west_red", mon_want.west_red, mon_got.west_red);
          compare_field("west_yellow", mon_want.west_yellow, mon_got.west_yellow);
          compare_field("west_green", mon_want.west_green, mon_got.west_green);
          compare_field("south_red", mon_want.south_red, mon_got.south_red);
          compare_field("south_yellow", mon_want.south_yellow, mon_got.south_yellow);
          compare_field("south_green", mon_want.south_green, mon_got.south_green);
          compare_field("count_tens", mon_want.count_tens, mon_got.count_tens);
          compare_field("count_units", mon_want.count_units, mon_got.count_units);
          compare_field("display_low_on", mon_want.display_low_on, mon_got.display_low_on);
          compare_field("display_high_on", mon_want.display_high_on, mon_got.display_high_on);
          words_checked++;
          if (!mon_want.display_low_on && !mon_want.display_high_on) hold_words++;
          if (mon_want.count_tens == 4'd9 && mon_want.count_units == 4'd9) capped_words++;
        end
      end
      m_axis_tready <= no_idle || $urandom_range(0, 99) >= 10;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("two_road_traffic_light_sequencer_top test failed");
      $finish;
    end
  end

  initial begin
    lens.south_phase_len   = trlseq_pkg::SouthPhaseLenRst;
    lens.south_yellow_len  = trlseq_pkg::SouthYellowLenRst;
    lens.west_yellow_len   = trlseq_pkg::WestYellowLenRst;
    lens.west_green_len    = trlseq_pkg::WestGreenLenRst;
    lens.manual_change_len = trlseq_pkg::ManualChangeLenRst;
    seq_phase              = trlseq_pkg::PhIdle;
    seq_left               = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset lengths: manual change and hold both ways, then into the auto cycle
    repeat (5) add_tick(1'b1, 1'b1);
    repeat (4) add_tick(1'b1, 1'b0);
    repeat (3) add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b1);
    repeat (3) add_tick(1'b0, 1'b0);
    drain_lights();

    // rewrite in the middle of the south countdown, yellow not below the phase
    set_lengths(7'd4, 7'd6, 7'd0, 7'd1, 7'd0, 1'b0);
    repeat (8) add_tick(1'b0, 1'b0);

    for (int run_idx = 0; run_idx < NumRuns; run_idx++) begin
      drain_lights();
      case (run_idx)
        0: set_lengths(7'd2, 7'd1, 7'd1, 7'd1, 7'd1, 1'b0);
        1: set_lengths(7'd99, 7'd98, 7'd99, 7'd99, 7'd99, 1'b0);
        2: set_lengths(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        3: set_lengths(7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 1'b0);
        4: set_lengths(7'd6, 7'd9, 7'd2, 7'd3, 7'd4, 1'b0);
        5: set_lengths(7'd8, 7'd3, 7'd2, 7'd5, 7'd2, 1'b1);
        default: set_lengths(7'($urandom_range(0, 12)), 7'($urandom_range(0, 12)),
                             7'($urandom_range(0, 12)), 7'($urandom_range(0, 12)),
                             7'($urandom_range(0, 12)), 1'b0);
      endcase
      no_idle = (run_idx == 5);
      fill_random(TicksPerRun);
    end

    drain_lights();
    repeat (10) @(posedge clk_i);
    $display("covered %0d tick words, %0d result words checked, %0d register sets",
             ticks_taken, words_checked, NumRuns + 2);
    $display("manual hold words: %0d, words showing 99: %0d", hold_words, capped_words);
    if (err_cnt == 0) begin
      $display("two_road_traffic_light_sequencer_top test passed");
    end else begin
      $display("two_road_traffic_light_sequencer_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/trlseq_pkg.sv
hw/rtl/trlseq_step.sv
hw/rtl/two_road_traffic_light_sequencer_top.sv
bench/two_road_traffic_light_sequencer_top_tb.sv
